// ===== src/css_pkg.sv =====
// Shared types, constants and helpers for the caseless substring search.
// No dependencies; every other file refers to this package by scoped names.
package css_pkg;

   localparam int MAX_PATTERN   = 32;
   localparam int POSITION_BITS = 16;
   localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
   localparam int IDX_BITS      = $clog2(MAX_PATTERN);
   localparam int WORD_BITS     = 64;
   localparam int BYTES_PER_WORD = WORD_BITS / 8;
   localparam int PATTERN_WORDS = MAX_PATTERN / BYTES_PER_WORD;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MATCH_POS_BITS = 16;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // CSR register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES_0 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES_3 = 3'd4;

   // Pattern view derived from the CSRs, held in a register.
   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] folded;  // case-folded pattern bytes
      logic [MAX_PATTERN-1:0]      active;  // bit i set: byte i is in the pattern
      logic [MAX_PATTERN-1:0]      last;    // one-hot at the final pattern byte
      logic [LEN_BITS-1:0]         len;     // effective length
   } pattern_type;

   typedef struct packed {
      logic                      found;
      logic [MATCH_POS_BITS-1:0] position;
   } result_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ===== src/caseless_substring_search.sv =====
// Top level of the caseless substring search: input register, scan core,
// result register and CSR port. Depends on css_pkg, css_cfg and css_scan.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------
//   req     | req_text_byte, req_end_of_text          | req_valid / req_stall
//   rsp     | rsp_found, rsp_match_position           | rsp_valid / rsp_stall
//   csr     | csr_index, csr_wdata                    | csr_valid / csr_ready
//
// One text byte per cycle sustained. A beat is held in the input
// register, is scanned against the whole pattern combinationally, and its
// result (end-of-text beats only) lands in the result register. Only an
// end-of-text beat waits on a stalled rsp; plain bytes keep flowing.
// Synchronous reset clears the scan state and CSRs. CSR writes take effect
// through the CSR registers and then the registered derived pattern view.
module caseless_substring_search (
   input  logic                                       clock,
   input  logic                                       reset,
   // text beats
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [7:0]                                 req_text_byte,
   input  logic                                       req_end_of_text,
   // result beats
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_found,
   output logic [css_pkg::MATCH_POS_BITS-1:0]         rsp_match_position,
   // CSR writes
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [css_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [css_pkg::WORD_BITS-1:0]              csr_wdata
);

   css_pkg::pattern_type pattern;
   css_pkg::result_type  result;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;
   logic       in_go;      // input register beat moves into the scan state
   logic       req_take;

   // Result register
   logic                      out_valid_ff, out_valid_in;
   css_pkg::result_type       out_ff;

   assign csr_ready = 1'b1;

   css_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pattern   (pattern)
   );

   // An end-of-text beat needs a free result slot (or one leaving now).
   assign in_go     = in_valid_ff && (!in_eot_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !in_go;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   css_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .go          (in_go),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .pattern     (pattern),
      .result      (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_go && in_eot_ff) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_go && in_eot_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_found          = out_ff.found;
   assign rsp_match_position = out_ff.position;

`ifndef NO_ASSERTIONS
   // A held input beat is not overwritten.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eot_ff))
      else $error("input register overwritten while stalled");

   // A scanned end-of-text beat always leaves a result waiting.
   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      in_go && in_eot_ff |=> out_valid_ff)
      else $error("end-of-text beat produced no result");

   // Derived pattern view stays consistent: at most one final byte, and zero length iff byte 0 is inactive.
   a_pattern_view: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pattern.last) && ((pattern.len == '0) == !pattern.active[0]))
      else $error("pattern view inconsistent");

   // No match reports position zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.found |-> out_ff.position == '0)
      else $error("miss with nonzero position");
`endif

endmodule

// ===== src/css_cfg.sv =====
// CSR block: pattern length and pattern words, plus the registered
// effective-pattern view. Depends on css_pkg.
module css_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [css_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [css_pkg::WORD_BITS-1:0]       csr_wdata,
   output css_pkg::pattern_type                pattern
);

   localparam int PAT_BITS = css_pkg::MAX_PATTERN * 8;

   logic [css_pkg::LEN_BITS-1:0]    length_ff;
   logic [PAT_BITS-1:0]             bytes_ff;
   css_pkg::pattern_type            pattern_ff;
   css_pkg::pattern_type            pattern_in;

   logic [css_pkg::MAX_PATTERN-1:0] nonzero;
   logic [css_pkg::IDX_BITS-1:0]    last_idx;
   logic [css_pkg::CSR_INDEX_BITS-1:0] word_sel;

   assign word_sel = csr_index - css_pkg::REG_PATTERN_BYTES_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         bytes_ff  <= '0;
      end else if (csr_valid) begin
         if (csr_index == css_pkg::REG_PATTERN_LENGTH) begin
            length_ff <= csr_wdata[css_pkg::LEN_BITS-1:0];
         end else if (csr_index >= css_pkg::REG_PATTERN_BYTES_0 &&
                      csr_index <= css_pkg::REG_PATTERN_BYTES_3) begin
            bytes_ff[word_sel[$clog2(css_pkg::PATTERN_WORDS)-1:0] *
                     css_pkg::WORD_BITS +: css_pkg::WORD_BITS] <= csr_wdata;
         end
      end
   end

   // Pattern runs up to the first zero byte or the capped length.
   always_comb begin
      for (int i = 0; i < css_pkg::MAX_PATTERN; i++) begin
         nonzero[i] = (bytes_ff[i*8 +: 8] != 8'd0) &&
                      (css_pkg::LEN_BITS'(i) < length_ff);
         pattern_in.folded[i] = css_pkg::fold_case(bytes_ff[i*8 +: 8]);
      end
      for (int i = 0; i < css_pkg::MAX_PATTERN; i++) begin
         pattern_in.active[i] =
            &(nonzero | ~css_pkg::MAX_PATTERN'((64'd1 << (i + 1)) - 64'd1));
      end
      pattern_in.last = pattern_in.active & ~(pattern_in.active >> 1);
      last_idx = '0;
      for (int i = 0; i < css_pkg::MAX_PATTERN; i++) begin
         last_idx = last_idx |
                    ({css_pkg::IDX_BITS{pattern_in.last[i]}} & css_pkg::IDX_BITS'(i));
      end
      if (pattern_in.active[0]) begin
         pattern_in.len = css_pkg::LEN_BITS'(last_idx) + css_pkg::LEN_BITS'(1);
      end else begin
         pattern_in.len = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
      end else begin
         pattern_ff <= pattern_in;
      end
   end

   assign pattern = pattern_ff;

endmodule

// ===== src/css_scan.sv =====
// Bit-parallel scan state: prefix match vector, position, first match.
// Produces the result of an end-of-text beat. Depends on css_pkg.
module css_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [7:0]                 text_byte,
   input  logic                       end_of_text,
   input  css_pkg::pattern_type       pattern,
   output css_pkg::result_type        result
);

   logic [css_pkg::MAX_PATTERN-1:0]   prefix_ff, prefix_in;
   logic [css_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic                              seen_ff, seen_in;
   logic [css_pkg::POSITION_BITS-1:0] start_ff, start_in;
   logic                              term_ff, term_in;

   logic [css_pkg::MAX_PATTERN-1:0]   eq;
   logic [7:0]                        fc;
   logic [css_pkg::POSITION_BITS:0]   end_plus;
   logic                              hit;

   always_comb begin
      prefix_in = prefix_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      start_in  = start_ff;
      term_in   = term_ff;
      fc        = css_pkg::fold_case(text_byte);
      end_plus  = {1'b0, pos_ff} + (css_pkg::POSITION_BITS + 1)'(1);
      for (int i = 0; i < css_pkg::MAX_PATTERN; i++) begin
         eq[i] = pattern.active[i] && (pattern.folded[i] == fc);
      end
      hit = 1'b0;
      if (!term_ff) begin
         if (text_byte == 8'd0) begin
            term_in = 1'b1;
         end else begin
            prefix_in = ((prefix_ff << 1) | css_pkg::MAX_PATTERN'(1)) & eq;
            hit = (pattern.len != '0) && !seen_ff && ((prefix_in & pattern.last) != '0);
            if (hit) begin
               seen_in = 1'b1;
               if (end_plus >= (css_pkg::POSITION_BITS + 1)'(pattern.len)) begin
                  start_in = css_pkg::POSITION_BITS'(
                     end_plus - (css_pkg::POSITION_BITS + 1)'(pattern.len));
               end else begin
                  start_in = '0;
               end
            end
            if (pos_ff != css_pkg::POS_MAX) begin
               pos_in = pos_ff + css_pkg::POSITION_BITS'(1);
            end
         end
      end
      // Result of this beat, used only when end_of_text is set
      if (pattern.len == '0) begin
         result.found    = 1'b1;
         result.position = '0;
      end else if (seen_in) begin
         result.found    = 1'b1;
         result.position = css_pkg::MATCH_POS_BITS'(start_in);
      end else begin
         result.found    = 1'b0;
         result.position = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         pos_ff    <= '0;
         seen_ff   <= 1'b0;
         start_ff  <= '0;
         term_ff   <= 1'b0;
      end else if (go) begin
         if (end_of_text) begin
            prefix_ff <= '0;
            pos_ff    <= '0;
            seen_ff   <= 1'b0;
            start_ff  <= '0;
            term_ff   <= 1'b0;
         end else begin
            prefix_ff <= prefix_in;
            pos_ff    <= pos_in;
            seen_ff   <= seen_in;
            start_ff  <= start_in;
            term_ff   <= term_in;
         end
      end
   end

endmodule
